// ===== hdl/ddp_pkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkt_pkg
// Shared constants, types and helpers of the DDP pixel packetizer.
// ----------------------------------------------------------------------------
package ddp_pkt_pkg;

	localparam int MAX_PIXELS_PER_PACKET = 480;
	localparam int MAX_DIMENSION         = 1024;

	localparam int DIM_W  = 11;
	localparam int ORD_W  = 3;
	localparam int IDX_W  = 2;
	localparam int OFF_W  = $clog2(MAX_DIMENSION * MAX_DIMENSION);
	localparam int TOT_W  = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
	localparam int FILL_W = $clog2(MAX_PIXELS_PER_PACKET);
	localparam int N_W    = $clog2(MAX_PIXELS_PER_PACKET + 1);
	localparam int SEQ_W  = 4;
	localparam int BIDX_W = 4;

	localparam logic [7:0]       DDP_FLAGS  = 8'h41;
	localparam logic [7:0]       DDP_TYPE   = 8'h01;
	localparam logic [7:0]       DDP_ID     = 8'h01;
	localparam logic [SEQ_W-1:0] SEQ_FIRST  = SEQ_W'(1);
	localparam logic [SEQ_W-1:0] SEQ_LAST   = SEQ_W'(15);

	localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(64);
	localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIMENSION);
	localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(1);

	// config register indexes
	localparam logic [IDX_W-1:0] REG_COLOR_ORDER  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(2);

	// color order codes
	localparam logic [ORD_W-1:0] ORD_RGB = ORD_W'(0);
	localparam logic [ORD_W-1:0] ORD_GRB = ORD_W'(1);
	localparam logic [ORD_W-1:0] ORD_BGR = ORD_W'(2);
	localparam logic [ORD_W-1:0] ORD_RBG = ORD_W'(3);
	localparam logic [ORD_W-1:0] ORD_GBR = ORD_W'(4);
	localparam logic [ORD_W-1:0] ORD_BRG = ORD_W'(5);

	// byte positions within one pixel's output
	localparam logic [BIDX_W-1:0] B_FLAGS = BIDX_W'(0);
	localparam logic [BIDX_W-1:0] B_SEQ   = BIDX_W'(1);
	localparam logic [BIDX_W-1:0] B_TYPE  = BIDX_W'(2);
	localparam logic [BIDX_W-1:0] B_ID    = BIDX_W'(3);
	localparam logic [BIDX_W-1:0] B_OFF3  = BIDX_W'(4);
	localparam logic [BIDX_W-1:0] B_OFF2  = BIDX_W'(5);
	localparam logic [BIDX_W-1:0] B_OFF1  = BIDX_W'(6);
	localparam logic [BIDX_W-1:0] B_OFF0  = BIDX_W'(7);
	localparam logic [BIDX_W-1:0] B_LEN1  = BIDX_W'(8);
	localparam logic [BIDX_W-1:0] B_LEN0  = BIDX_W'(9);
	localparam logic [BIDX_W-1:0] B_C0    = BIDX_W'(10);
	localparam logic [BIDX_W-1:0] B_C1    = BIDX_W'(11);
	localparam logic [BIDX_W-1:0] B_C2    = BIDX_W'(12);

	typedef struct packed {
		logic             hdr;
		logic [SEQ_W-1:0] seq;
		logic [31:0]      boff;
		logic [15:0]      len;
		logic [7:0]       c0;
		logic [7:0]       c1;
		logic [7:0]       c2;
		logic             pkt_end;
		logic             frm_end;
	} pixel_desc_t;

	typedef struct packed {
		logic [ORD_W-1:0] color_order;
		logic [TOT_W-1:0] total;
		logic             hold;
	} cfg_state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_MIN)
			r = DIM_MIN;
		else if (v > DIM_MAX)
			r = DIM_MAX;
		return r;
	endfunction

endpackage

// ===== hdl/ddp_pixel_packetizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pixel_packetizer
// Turns a stream of 24-bit RGB pixels into a DDP byte stream.
// ----------------------------------------------------------------------------
// The block puts out one byte per clock, unless byte_stall holds the output,
// through a single registered byte port, so a pixel is 3 bytes, or 13 bytes
// when it opens a packet and carries the 10-byte header. The next pixel is
// taken in the cycle its predecessor's last byte enters the output register,
// so a steady stream runs with no gaps. A configuration write holds off pixel
// requests for one cycle while the frame size register settles.
module ddp_pixel_packetizer
	import ddp_pkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  logic [23:0]      pixel_rgb,
	output logic             byte_valid,
	input  logic             byte_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             packet_last,
	output logic             frame_last
);

	cfg_state_t  cfg;
	pixel_desc_t desc;
	logic        free;
	logic        accept;

	assign cfg_ready   = 1'b1;
	assign pixel_stall = cfg.hold || !free;
	assign accept      = pixel_valid && !pixel_stall;

	ddp_pkt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ddp_pkt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel_rgb (pixel_rgb),
		.cfg       (cfg),
		.desc      (desc)
	);

	ddp_pkt_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.desc        (desc),
		.free        (free),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.packet_last (packet_last),
		.frame_last  (frame_last)
	);

endmodule

// ===== hdl/ddp_pkt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkt_cfg
// Configuration registers and registered frame size.
// ----------------------------------------------------------------------------
module ddp_pkt_cfg
	import ddp_pkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output cfg_state_t       cfg
);

	logic [ORD_W-1:0] order_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [TOT_W-1:0] total_q;
	logic             hold_q;
	logic             wr;
	logic [2*DIM_W-1:0] prod;

	assign wr   = cfg_valid && cfg_ready;
	assign prod = clamp_dim(width_q) * clamp_dim(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= ORD_RGB;
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			total_q  <= TOT_W'(DIM_RESET) * TOT_W'(DIM_RESET);
			hold_q   <= 1'b0;
		end else begin
			hold_q  <= wr;
			total_q <= prod[TOT_W-1:0];
			if (wr) begin
				case (cfg_index)
					REG_COLOR_ORDER:  order_q  <= cfg_data[ORD_W-1:0];
					REG_FRAME_WIDTH:  width_q  <= cfg_data;
					REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// new frame size passes through width_q/height_q and then total_q after a write
	assign cfg.color_order = order_q;
	assign cfg.total       = total_q;
	assign cfg.hold        = hold_q;

endmodule

// ===== hdl/ddp_pkt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkt_front
// Frame and packet position tracking; builds the descriptor of one pixel.
// ----------------------------------------------------------------------------
module ddp_pkt_front
	import ddp_pkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [23:0] pixel_rgb,
	input  cfg_state_t  cfg,
	output pixel_desc_t desc
);

	logic [OFF_W-1:0]  offset_q;
	logic [FILL_W-1:0] fill_q;
	logic [SEQ_W-1:0]  seq_q;

	logic              wrap;
	logic [OFF_W-1:0]  off_eff;
	logic [FILL_W-1:0] fill_eff;
	logic [TOT_W-1:0]  left;
	logic [N_W-1:0]    n;
	logic              frm_end;
	logic              pkt_end;
	logic [7:0]        r, g, b;

	assign wrap     = {1'b0, offset_q} >= cfg.total;
	assign off_eff  = wrap ? '0 : offset_q;
	assign fill_eff = wrap ? '0 : fill_q;
	assign left     = cfg.total - TOT_W'(off_eff);
	assign n        = (left < TOT_W'(MAX_PIXELS_PER_PACKET)) ? left[N_W-1:0]
	                                                         : N_W'(MAX_PIXELS_PER_PACKET);
	assign frm_end  = left == TOT_W'(1);
	assign pkt_end  = frm_end || ((N_W'(fill_eff) + N_W'(1)) >= N_W'(MAX_PIXELS_PER_PACKET));

	assign r = pixel_rgb[23:16];
	assign g = pixel_rgb[15:8];
	assign b = pixel_rgb[7:0];

	always_comb begin
		desc.hdr     = fill_eff == '0;
		desc.seq     = seq_q;
		desc.boff    = {31'(off_eff), 1'b0} + 32'(off_eff);
		desc.len     = {15'(n), 1'b0} + 16'(n);
		desc.pkt_end = pkt_end;
		desc.frm_end = frm_end;
		case (cfg.color_order)
			ORD_GRB: begin desc.c0 = g; desc.c1 = r; desc.c2 = b; end
			ORD_BGR: begin desc.c0 = b; desc.c1 = g; desc.c2 = r; end
			ORD_RBG: begin desc.c0 = r; desc.c1 = b; desc.c2 = g; end
			ORD_GBR: begin desc.c0 = g; desc.c1 = b; desc.c2 = r; end
			ORD_BRG: begin desc.c0 = b; desc.c1 = r; desc.c2 = g; end
			default: begin desc.c0 = r; desc.c1 = g; desc.c2 = b; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			fill_q   <= '0;
			seq_q    <= SEQ_FIRST;
		end else if (accept) begin
			if (frm_end) begin
				offset_q <= '0;
				fill_q   <= '0;
				seq_q    <= (seq_q == SEQ_LAST) ? SEQ_FIRST : seq_q + SEQ_W'(1);
			end else begin
				offset_q <= off_eff + OFF_W'(1);
				fill_q   <= pkt_end ? '0 : fill_eff + FILL_W'(1);
			end
		end
	end

endmodule

// ===== hdl/ddp_pkt_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkt_ser
// Holds one pixel descriptor and sends its bytes through the output register.
// ----------------------------------------------------------------------------
module ddp_pkt_ser
	import ddp_pkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  pixel_desc_t desc,
	output logic        free,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        packet_last,
	output logic        frame_last
);

	pixel_desc_t       desc_s1;
	logic              desc_valid_q;
	logic [BIDX_W-1:0] idx_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              run_last_q;
	logic              packet_last_q;
	logic              frame_last_q;

	logic              advance;
	logic              last_byte;
	logic [7:0]        sel;

	assign advance   = desc_valid_q && (!out_valid_q || !byte_stall);
	assign last_byte = idx_q == B_C2;
	assign free      = !desc_valid_q || (advance && last_byte);

	always_comb begin
		case (idx_q)
			B_FLAGS: sel = DDP_FLAGS;
			B_SEQ:   sel = 8'(desc_s1.seq);
			B_TYPE:  sel = DDP_TYPE;
			B_ID:    sel = DDP_ID;
			B_OFF3:  sel = desc_s1.boff[31:24];
			B_OFF2:  sel = desc_s1.boff[23:16];
			B_OFF1:  sel = desc_s1.boff[15:8];
			B_OFF0:  sel = desc_s1.boff[7:0];
			B_LEN1:  sel = desc_s1.len[15:8];
			B_LEN0:  sel = desc_s1.len[7:0];
			B_C0:    sel = desc_s1.c0;
			B_C1:    sel = desc_s1.c1;
			default: sel = desc_s1.c2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_s1 <= desc;
		if (advance) begin
			byte_q        <= sel;
			run_last_q    <= last_byte;
			packet_last_q <= last_byte && desc_s1.pkt_end;
			frame_last_q  <= last_byte && desc_s1.frm_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_valid_q <= 1'b0;
			idx_q        <= B_FLAGS;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				desc_valid_q <= 1'b1;
				idx_q        <= desc.hdr ? B_FLAGS : B_C0;
			end else if (advance && last_byte) begin
				desc_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + BIDX_W'(1);
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (!byte_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign byte_valid  = out_valid_q;
	assign out_byte    = byte_q;
	assign run_last    = run_last_q;
	assign packet_last = packet_last_q;
	assign frame_last  = frame_last_q;

endmodule
